@@ design/encoder_period_speed_meter_defines.svh @@
// Assertion macros used by the checker file of the encoder speed meter.
`ifndef ENCODER_PERIOD_SPEED_METER_DEFINES_SVH
`define ENCODER_PERIOD_SPEED_METER_DEFINES_SVH

// Property checked on every rising clock edge while reset is released.
`define EPSM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Property checked on every rising clock edge, reset cycles included.
`define EPSM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/epsm_pkg.sv @@
package epsm_pkg;

    // Field widths.
    localparam int TIME_W    = 32;
    localparam int SPEED_W   = 32;
    localparam int COUNT_W   = 16;
    localparam int NUM_W     = 31;
    localparam int LIMIT_W   = 24;
    localparam int REV_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 31;

    // Default structure sizes.
    localparam int DEF_CHANNELS    = 2;
    localparam int DEF_QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_NUMERATOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_LEVELS = 2'd2;

    // Configuration reset values.
    localparam logic [NUM_W-1:0]   RST_RATE_NUMERATOR = 31'd16000000;
    localparam logic [LIMIT_W-1:0] RST_STALL_LIMIT    = 24'd800000;
    localparam logic [REV_W-1:0]   RST_REVERSE_LEVELS = 2'd1;

    // Item function codes.
    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Largest speed magnitude, used when the period is zero.
    localparam logic [SPEED_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;

    // One division step per quotient bit.
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    // Work handed from the front end to the divider.
    typedef struct packed {
        logic [TIME_W-1:0]  period;
        logic [NUM_W-1:0]   numerator;
        logic               negate;
        logic               stopped;
        logic [COUNT_W-1:0] edge_count;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_DONE
    } t_back_state;

endpackage

@@ design/encoder_period_speed_meter.sv @@
// Speed meter for a set of quadrature-encoder channels.
//
// Input channel: i_valid / o_stall with i_func, i_channel, i_capture_time and
// i_phase_b_level. A transfer with i_func low is a rising A-phase edge on
// i_channel; with i_func high it is one stall timer tick for all channels.
// Output channel: o_valid / i_stall with o_speed, o_edge_count, o_stopped.
// Every input transfer yields exactly one output transfer, in order.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// o_cfg_ready is always high, and writes are meant for an idle block.
// Path: an item that computes a quotient is written into the queue, popped
// into the back end's job register, passes through 31 steps of the
// restoring divider and is then loaded into the output register.
// Stopped channels and zero periods skip the divider.
// The back end takes its next item only after loading the last result.
// A two-entry queue separates the front end from the divider, so items are
// accepted while a result waits. When i_stall holds the output, the divider
// finishes its item and waits; o_stall rises once the queue is full.
// Synchronous reset (i_rst_n low) clears all channel state and the queue,
// drops o_valid and restores the configuration defaults.
module encoder_period_speed_meter #(
    parameter int CHANNELS    = epsm_pkg::DEF_CHANNELS,
    parameter int QUEUE_DEPTH = epsm_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_func,
    input  logic                                i_channel,
    input  logic [epsm_pkg::TIME_W-1:0]         i_capture_time,
    input  logic                                i_phase_b_level,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [epsm_pkg::SPEED_W-1:0] o_speed,
    output logic [epsm_pkg::COUNT_W-1:0]        o_edge_count,
    output logic                                o_stopped,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [epsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [epsm_pkg::CFG_W-1:0]          i_cfg_data
);
    import epsm_pkg::*;

    // Configuration registers.
    logic [NUM_W-1:0]   r_rate_numerator;
    logic [LIMIT_W-1:0] r_stall_limit;
    logic [REV_W-1:0]   r_reverse_levels;

    t_queue_status q_status;
    t_job          push_job;
    t_job          head_job;
    logic          push;
    logic          pop;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_status.full;

    // Writes to an index beyond the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_numerator <= RST_RATE_NUMERATOR;
            r_stall_limit    <= RST_STALL_LIMIT;
            r_reverse_levels <= RST_REVERSE_LEVELS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RATE_NUMERATOR: r_rate_numerator <= i_cfg_data[NUM_W-1:0];
                CFG_STALL_LIMIT:    r_stall_limit    <= i_cfg_data[LIMIT_W-1:0];
                CFG_REVERSE_LEVELS: r_reverse_levels <= i_cfg_data[REV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: updates the per-channel state and packs the division job.
    epsm_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (i_valid),
        .i_func           (i_func),
        .i_channel        (i_channel),
        .i_capture_time   (i_capture_time),
        .i_phase_b_level  (i_phase_b_level),
        .i_rate_numerator (r_rate_numerator),
        .i_stall_limit    (r_stall_limit),
        .i_reverse_levels (r_reverse_levels),
        .i_q_status       (q_status),
        .o_push           (push),
        .o_job            (push_job)
    );

    epsm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    // Back end: divides, applies sign and saturation, holds the result.
    epsm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_status   (q_status),
        .i_job        (head_job),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_speed      (o_speed),
        .o_edge_count (o_edge_count),
        .o_stopped    (o_stopped)
    );

endmodule

@@ design/epsm_queue.sv @@
module epsm_queue #(
    parameter int DEPTH = epsm_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  epsm_pkg::t_job            i_job,
    input  logic                      i_pop,
    output epsm_pkg::t_job            o_job,
    output epsm_pkg::t_queue_status   o_status
);
    import epsm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push_ok, pop_ok;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_job          = r_mem[r_head];

    assign push_ok = i_push && !o_status.full;
    assign pop_ok  = i_pop && !o_status.empty;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (push_ok) begin
            n_tail = (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (pop_ok) begin
            n_head = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_tail] <= i_job;
        end
    end

endmodule

@@ design/epsm_front.sv @@
module epsm_front #(
    parameter int CHANNELS = epsm_pkg::DEF_CHANNELS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    input  logic                          i_func,
    input  logic                          i_channel,
    input  logic [epsm_pkg::TIME_W-1:0]   i_capture_time,
    input  logic                          i_phase_b_level,
    input  logic [epsm_pkg::NUM_W-1:0]    i_rate_numerator,
    input  logic [epsm_pkg::LIMIT_W-1:0]  i_stall_limit,
    input  logic [epsm_pkg::REV_W-1:0]    i_reverse_levels,
    input  epsm_pkg::t_queue_status       i_q_status,
    output logic                          o_push,
    output epsm_pkg::t_job                o_job
);
    import epsm_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [TIME_W-1:0]  r_last     [CHANNELS];
    logic [TIME_W-1:0]  r_period   [CHANNELS];
    logic [COUNT_W-1:0] r_edges    [CHANNELS];
    logic               r_dir      [CHANNELS];
    logic               r_stopped  [CHANNELS];
    logic [LIMIT_W-1:0] r_stall    [CHANNELS];

    logic [TIME_W-1:0]  n_last     [CHANNELS];
    logic [TIME_W-1:0]  n_period   [CHANNELS];
    logic [COUNT_W-1:0] n_edges    [CHANNELS];
    logic               n_dir      [CHANNELS];
    logic               n_stopped  [CHANNELS];
    logic [LIMIT_W-1:0] n_stall    [CHANNELS];

    logic [CH_W-1:0]    ch;
    logic               accept;
    logic               rev_bit;
    logic [LIMIT_W-1:0] bumped;

    // The channel field wraps modulo the channel count.
    assign ch     = (CHANNELS == 1) ? '0 : CH_W'(i_channel);
    assign accept = i_item_valid && !i_q_status.full;
    assign o_push = accept;

    always_comb begin
        for (int k = 0; k < CHANNELS; k++) begin
            n_last[k]    = r_last[k];
            n_period[k]  = r_period[k];
            n_edges[k]   = r_edges[k];
            n_dir[k]     = r_dir[k];
            n_stopped[k] = r_stopped[k];
            n_stall[k]   = r_stall[k];
        end
        bumped = '0;
        if (i_func == FUNC_EDGE) begin
            n_period[ch]  = i_capture_time - r_last[ch];
            n_last[ch]    = i_capture_time;
            n_dir[ch]     = i_phase_b_level;
            n_edges[ch]   = r_edges[ch] + 1'b1;
            n_stopped[ch] = 1'b0;
            n_stall[ch]   = '0;
        end else begin
            for (int k = 0; k < CHANNELS; k++) begin
                bumped = r_stall[k] + 1'b1;
                if (bumped >= i_stall_limit) begin
                    n_stopped[k] = 1'b1;
                    n_stall[k]   = '0;
                end else begin
                    n_stall[k] = bumped;
                end
            end
        end
    end

    // Only the first two channels have a reverse bit.
    assign rev_bit = (32'(ch) < 32'(REV_W)) ? i_reverse_levels[ch[0]] : 1'b0;

    always_comb begin
        o_job.period     = n_period[ch];
        o_job.numerator  = i_rate_numerator;
        o_job.negate     = (n_dir[ch] == rev_bit);
        o_job.stopped    = n_stopped[ch];
        o_job.edge_count = n_edges[ch];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_last[k]    <= '0;
                r_period[k]  <= '0;
                r_edges[k]   <= '0;
                r_dir[k]     <= 1'b0;
                r_stopped[k] <= 1'b0;
                r_stall[k]   <= '0;
            end
        end else if (accept) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_last[k]    <= n_last[k];
                r_period[k]  <= n_period[k];
                r_edges[k]   <= n_edges[k];
                r_dir[k]     <= n_dir[k];
                r_stopped[k] <= n_stopped[k];
                r_stall[k]   <= n_stall[k];
            end
        end
    end

endmodule

@@ design/epsm_back.sv @@
module epsm_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  epsm_pkg::t_queue_status             i_q_status,
    input  epsm_pkg::t_job                      i_job,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [epsm_pkg::SPEED_W-1:0] o_speed,
    output logic [epsm_pkg::COUNT_W-1:0]        o_edge_count,
    output logic                                o_stopped
);
    import epsm_pkg::*;

    t_back_state        r_state, n_state;
    t_job               r_job, n_job;
    logic [TIME_W-1:0]  r_rem, n_rem;
    logic [NUM_W-1:0]   r_quo, n_quo;
    logic [STEP_W-1:0]  r_step, n_step;

    logic               r_valid, n_valid;
    logic [SPEED_W-1:0] r_speed, n_speed;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_stopped, n_stopped;

    logic [TIME_W:0]    trial;
    logic [TIME_W:0]    diff;
    logic [SPEED_W-1:0] mag;

    assign o_valid      = r_valid;
    assign o_speed      = r_speed;
    assign o_edge_count = r_count;
    assign o_stopped    = r_stopped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_step    <= n_step;
        r_speed   <= n_speed;
        r_count   <= n_count;
        r_stopped <= n_stopped;
    end

    // Restoring division: one quotient bit per cycle.
    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign diff  = trial - {1'b0, r_job.period};

    always_comb begin
        if (r_job.stopped) begin
            mag = '0;
        end else if (r_job.period == '0) begin
            mag = SPEED_MAX;
        end else begin
            mag = SPEED_W'(r_quo);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_step    = r_step;
        n_valid   = r_valid;
        n_speed   = r_speed;
        n_count   = r_count;
        n_stopped = r_stopped;
        o_pop     = 1'b0;

        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end

        case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop  = 1'b1;
                    n_job  = i_job;
                    n_rem  = '0;
                    n_quo  = i_job.numerator;
                    n_step = '0;
                    if (i_job.stopped || (i_job.period == '0)) begin
                        n_state = BK_DONE;
                    end else begin
                        n_state = BK_DIVIDE;
                    end
                end
            end
            BK_DIVIDE: begin
                if (!diff[TIME_W]) begin
                    n_rem = diff[TIME_W-1:0];
                    n_quo = {r_quo[NUM_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[TIME_W-1:0];
                    n_quo = {r_quo[NUM_W-2:0], 1'b0};
                end
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!r_valid || !i_stall) begin
                    n_valid   = 1'b1;
                    n_speed   = r_job.negate ? (SPEED_W'(0) - mag) : mag;
                    n_count   = r_job.edge_count;
                    n_stopped = r_job.stopped;
                    n_state   = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

endmodule

@@ design/epsm_checker.sv @@
`include "encoder_period_speed_meter_defines.svh"

module epsm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_speed,
    input logic [15:0] o_edge_count,
    input logic        o_stopped
);

    // A held result must not change under stall.
    `EPSM_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_speed) && $stable(o_edge_count) && $stable(o_stopped), "result changed while stalled")

    // A stopped channel always reports zero speed.
    `EPSM_ASSERT(a_stopped_zero, i_clk, i_rst_n, o_valid && o_stopped |-> o_speed == 32'd0, "stopped channel with nonzero speed")

    // The magnitude saturates, so the most negative code never appears.
    `EPSM_ASSERT(a_speed_range, i_clk, i_rst_n, o_valid |-> o_speed != 32'h8000_0000, "speed outside the saturated range")

    // Reset empties the output register.
    `EPSM_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid, "result present after reset")

endmodule

bind encoder_period_speed_meter epsm_checker u_checker (.*);
